/* rtl/core/vna_pkg.sv */
// Shared types and constants of the vertex normal accumulator.
// Used by every module of the block but vna_ram; depends on nothing.
package vna_pkg;

	localparam int IDX_W  = 10;
	localparam int POS_W  = 16;
	localparam int NRM_W  = 16;
	localparam int VEC_W  = 35;
	localparam int MAG_W  = 34;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_TRI  = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_TRI,
		OP_READ,
		OP_READ_BAD
	} op_kind_t;

	typedef struct packed {
		op_kind_t                 kind;
		logic [IDX_W-1:0]         idx;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [POS_W-1:0]  pz;
		logic [IDX_W-1:0]         ca;
		logic [IDX_W-1:0]         cb;
		logic [IDX_W-1:0]         cc;
	} op_t;

	typedef struct packed {
		logic                     ok;
		logic signed [NRM_W-1:0]  nx;
		logic signed [NRM_W-1:0]  ny;
		logic signed [NRM_W-1:0]  nz;
	} unit_res_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_SHIFT,
		U_SQUARE,
		U_SQRT,
		U_DLOAD,
		U_DIV,
		U_DONE
	} unit_state_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_LOAD,
		B_TRI_RD,
		B_EDGE,
		B_MUL,
		B_CROSS,
		B_START,
		B_WAIT,
		B_ACC_RD,
		B_ACC_WR,
		B_RD_ISSUE,
		B_RD_DATA,
		B_OUT
	} back_state_t;

endpackage

/* rtl/core/vna_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/vna_front.sv */
// Front end: checks and classifies accepted items and queues them as operations.
// Depends on vna_pkg.
module vna_front import vna_pkg::*; #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [1:0]              cmd,
	input  logic [IDX_W-1:0]        vertex_index,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [IDX_W-1:0]        corner_a,
	input  logic [IDX_W-1:0]        corner_b,
	input  logic [IDX_W-1:0]        corner_c,
	input  logic                    op_take,
	output logic                    op_valid,
	output op_t                     op_head,
	output logic                    q_full
);

	localparam logic [31:0] MAXV = 32'(MAX_VERTICES);

	op_t               fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              enq;
	op_t               op_in;

	function automatic logic in_range(input logic [IDX_W-1:0] i);
		return 32'(i) < MAXV;
	endfunction

	always_comb begin
		op_in.kind = OP_LOAD;
		op_in.idx  = vertex_index;
		op_in.px   = pos_x;
		op_in.py   = pos_y;
		op_in.pz   = pos_z;
		op_in.ca   = corner_a;
		op_in.cb   = corner_b;
		op_in.cc   = corner_c;
		enq        = 1'b0;
		case (cmd)
			CMD_LOAD: begin
				enq = in_range(vertex_index);
			end
			CMD_TRI: begin
				op_in.kind = OP_TRI;
				enq = in_range(corner_a) && in_range(corner_b) && in_range(corner_c);
			end
			CMD_READ: begin
				// An out of range read still answers, as a degenerate result.
				op_in.kind = in_range(vertex_index) ? OP_READ : OP_READ_BAD;
				enq = 1'b1;
			end
			default: begin
				enq = 1'b0;
			end
		endcase
	end

	assign q_full   = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign op_valid = (cnt_q != '0);
	assign op_head  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept && enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (op_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if ((accept && enq) && !op_take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(accept && enq) && op_take) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && enq) begin
			fifo_q[wr_ptr_q] <= op_in;
		end
	end

endmodule

/* rtl/core/vna_unit.sv */
// Iterative vector normalizer: scales a vector to unit length in Q1.14.
// Bit-serial square root and restoring division; depends on vna_pkg.
module vna_unit import vna_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [VEC_W-1:0] vx,
	input  logic signed [VEC_W-1:0] vy,
	input  logic signed [VEC_W-1:0] vz,
	output logic                    done,
	output unit_res_t               res
);

	unit_state_t      state_q, state_d;
	logic [MAG_W-1:0] mag_q [3];
	logic             neg_q [3];
	logic [59:0]      prod_q;
	logic [61:0]      sum_q;
	logic [1:0]       cnt_q;
	logic [63:0]      s_q, root_q, bit_q;
	logic [30:0]      len_q;
	logic [45:0]      rem_q;
	logic [14:0]      quo_q;
	logic [3:0]       bcnt_q;
	logic [1:0]       comp_q;
	unit_res_t        res_q;

	logic [1:0]        sel;
	logic [29:0]       msel;
	logic [63:0]       t;
	logic              sq_ge;
	logic [63:0]       root_nx;
	logic [45:0]       dvs;
	logic              dv_ge;
	logic [14:0]       quo_nx;
	logic              big;
	logic signed [NRM_W-1:0] q16, nval;

	function automatic logic [MAG_W-1:0] abs_mag(input logic signed [VEC_W-1:0] v);
		logic [VEC_W-1:0] a;
		a = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
		return a[MAG_W-1:0];
	endfunction

	always_comb begin
		sel = (state_q == U_SQUARE) ? cnt_q : comp_q;
		case (sel)
			2'd0:    msel = mag_q[0][29:0];
			2'd1:    msel = mag_q[1][29:0];
			default: msel = mag_q[2][29:0];
		endcase
		t       = root_q + bit_q;
		sq_ge   = (s_q >= t);
		root_nx = sq_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
		dvs     = 46'(len_q) << bcnt_q;
		dv_ge   = (rem_q >= dvs);
		quo_nx  = quo_q | (15'(dv_ge) << bcnt_q);
		big     = (mag_q[0][MAG_W-1:30] != '0) || (mag_q[1][MAG_W-1:30] != '0) ||
			(mag_q[2][MAG_W-1:30] != '0);
		q16     = {1'b0, quo_nx};
		nval    = neg_q[comp_q == 2'd0 ? 0 : (comp_q == 2'd1 ? 1 : 2)] ? -q16 : q16;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			U_IDLE:   if (start) state_d = U_SHIFT;
			U_SHIFT:  if (!big) state_d = U_SQUARE;
			U_SQUARE: if (cnt_q == 2'd3) state_d = U_SQRT;
			U_SQRT: begin
				if (bit_q == 64'd1) begin
					state_d = (root_nx == '0) ? U_DONE : U_DLOAD;
				end
			end
			U_DLOAD:  state_d = U_DIV;
			U_DIV: begin
				if (bcnt_q == '0) begin
					state_d = (comp_q == 2'd2) ? U_DONE : U_DLOAD;
				end
			end
			U_DONE:   state_d = U_IDLE;
			default:  state_d = U_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == U_DONE);
		res  = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (start) begin
					mag_q[0] <= abs_mag(vx);
					mag_q[1] <= abs_mag(vy);
					mag_q[2] <= abs_mag(vz);
					neg_q[0] <= vx[VEC_W-1];
					neg_q[1] <= vy[VEC_W-1];
					neg_q[2] <= vz[VEC_W-1];
					sum_q    <= '0;
					cnt_q    <= '0;
					comp_q   <= '0;
				end
			end
			U_SHIFT: begin
				// Halve all components together until each fits below 2^30.
				if (big) begin
					mag_q[0] <= mag_q[0] >> 1;
					mag_q[1] <= mag_q[1] >> 1;
					mag_q[2] <= mag_q[2] >> 1;
				end
			end
			U_SQUARE: begin
				prod_q <= msel * msel;
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q != 2'd0) begin
					sum_q <= sum_q + 62'(prod_q);
				end
				if (cnt_q == 2'd3) begin
					s_q    <= 64'(sum_q) + 64'(prod_q);
					root_q <= '0;
					bit_q  <= 64'd1 << 62;
				end
			end
			U_SQRT: begin
				if (sq_ge) begin
					s_q <= s_q - t;
				end
				root_q <= root_nx;
				bit_q  <= bit_q >> 2;
				if (bit_q == 64'd1) begin
					len_q    <= root_nx[30:0];
					res_q.ok <= (root_nx != '0);
					res_q.nx <= '0;
					res_q.ny <= '0;
					res_q.nz <= '0;
				end
			end
			U_DLOAD: begin
				// Numerator m * 2^14 plus half the length rounds the quotient.
				rem_q  <= 46'({msel, 14'd0}) + 46'(len_q >> 1);
				quo_q  <= '0;
				bcnt_q <= 4'd14;
			end
			U_DIV: begin
				if (dv_ge) begin
					rem_q <= rem_q - dvs;
				end
				quo_q  <= quo_nx;
				bcnt_q <= bcnt_q - 1'b1;
				if (bcnt_q == '0) begin
					case (comp_q)
						2'd0:    res_q.nx <= nval;
						2'd1:    res_q.ny <= nval;
						default: res_q.nz <= nval;
					endcase
					comp_q <= comp_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/core/vna_back.sv */
// Back end: sequencer that carries out queued operations against the position
// and accumulator RAMs, using the normalizer; holds the result register.
// Depends on vna_pkg, vna_ram and vna_unit.
module vna_back import vna_pkg::*; #(
	parameter int MAX_VERTICES = 1024,
	parameter int ACCUM_BITS   = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    op_valid,
	input  op_t                     op_head,
	output logic                    op_take,
	output logic                    clearing,
	output logic                    empty,
	input  logic                    pop,
	output logic [IDX_W-1:0]        out_vertex,
	output logic signed [NRM_W-1:0] normal_x,
	output logic signed [NRM_W-1:0] normal_y,
	output logic signed [NRM_W-1:0] normal_z,
	output logic                    degenerate
);

	localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int AB  = ACCUM_BITS;
	localparam int ACW = 3 * ACCUM_BITS;
	localparam int PW  = 3 * POS_W;

	back_state_t state_q, state_d;
	op_t         op_q;
	logic [1:0]  cnt_q;
	logic [AW-1:0] clr_q;
	logic [PW-1:0] p_q [3];
	logic signed [POS_W:0] e1_q [3];
	logic signed [POS_W:0] e2_q [3];
	logic signed [2*POS_W+1:0] prod_q [6];
	logic signed [VEC_W-1:0] vec_q [3];
	logic out_full_q;
	logic [IDX_W-1:0] out_vertex_q;
	logic signed [NRM_W-1:0] out_nx_q, out_ny_q, out_nz_q;
	logic out_deg_q;

	logic          pos_we;
	logic [AW-1:0] pos_waddr, pos_raddr;
	logic [PW-1:0] pos_wdata, pos_rdata;
	logic          acc_we;
	logic [AW-1:0] acc_waddr, acc_raddr;
	logic [ACW-1:0] acc_wdata, acc_rdata;
	logic          unit_start, unit_done;
	unit_res_t     unit_res;
	logic          out_load;
	logic [IDX_W-1:0] corner;

	function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] i);
		logic [31:0] w;
		w = 32'(i);
		return w[AW-1:0];
	endfunction

	function automatic logic signed [POS_W:0] pcomp(input logic [PW-1:0] p, input int k);
		logic signed [POS_W-1:0] c;
		c = $signed(p[PW-1-k*POS_W -: POS_W]);
		return (POS_W+1)'(c);
	endfunction

	function automatic logic [AB-1:0] sat_add(input logic [AB-1:0] a,
		input logic signed [NRM_W-1:0] n);
		logic signed [AB:0] s;
		s = (AB+1)'($signed(a)) + (AB+1)'(n);
		if (s[AB] != s[AB-1]) begin
			return s[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
		end
		return s[AB-1:0];
	endfunction

	vna_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	vna_ram #(.WIDTH(ACW), .DEPTH(MAX_VERTICES)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	vna_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.vx     (vec_q[0]),
		.vy     (vec_q[1]),
		.vz     (vec_q[2]),
		.done   (unit_done),
		.res    (unit_res)
	);

	always_comb begin
		case (cnt_q)
			2'd0:    corner = op_q.ca;
			2'd1:    corner = op_q.cb;
			default: corner = op_q.cc;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: if (clr_q == AW'(MAX_VERTICES - 1)) state_d = B_IDLE;
			B_IDLE: begin
				if (op_valid) begin
					case (op_head.kind)
						OP_LOAD: state_d = B_LOAD;
						OP_TRI:  state_d = B_TRI_RD;
						OP_READ: state_d = B_RD_ISSUE;
						default: state_d = B_OUT;
					endcase
				end
			end
			B_LOAD:     state_d = B_IDLE;
			B_TRI_RD:   if (cnt_q == 2'd3) state_d = B_EDGE;
			B_EDGE:     state_d = B_MUL;
			B_MUL:      state_d = B_CROSS;
			B_CROSS:    state_d = B_START;
			B_START:    state_d = B_WAIT;
			B_WAIT: begin
				if (unit_done) begin
					if (op_q.kind == OP_TRI) begin
						// A zero face normal adds nothing.
						state_d = unit_res.ok ? B_ACC_RD : B_IDLE;
					end else begin
						state_d = B_OUT;
					end
				end
			end
			B_ACC_RD:   state_d = B_ACC_WR;
			B_ACC_WR:   state_d = (cnt_q == 2'd2) ? B_IDLE : B_ACC_RD;
			B_RD_ISSUE: state_d = B_RD_DATA;
			B_RD_DATA:  state_d = B_START;
			B_OUT:      if (!out_full_q || pop) state_d = B_IDLE;
			default:    state_d = B_IDLE;
		endcase
	end

	always_comb begin
		op_take    = (state_q == B_IDLE) && op_valid;
		clearing   = (state_q == B_CLEAR);
		unit_start = (state_q == B_START);
		out_load   = (state_q == B_OUT) && (!out_full_q || pop);
		pos_we     = (state_q == B_LOAD);
		pos_waddr  = to_addr(op_q.idx);
		pos_wdata  = {op_q.px, op_q.py, op_q.pz};
		pos_raddr  = to_addr(corner);
		acc_we     = 1'b0;
		acc_waddr  = to_addr(corner);
		acc_wdata  = '0;
		acc_raddr  = (state_q == B_RD_ISSUE) ? to_addr(op_q.idx) : to_addr(corner);
		case (state_q)
			B_CLEAR: begin
				acc_we    = 1'b1;
				acc_waddr = clr_q;
			end
			B_LOAD: begin
				acc_we    = 1'b1;
				acc_waddr = to_addr(op_q.idx);
			end
			B_ACC_WR: begin
				acc_we    = 1'b1;
				acc_wdata = {sat_add(acc_rdata[ACW-1 -: AB], unit_res.nx),
					sat_add(acc_rdata[2*AB-1 -: AB], unit_res.ny),
					sat_add(acc_rdata[AB-1:0], unit_res.nz)};
			end
			default: begin
			end
		endcase
		empty      = !out_full_q;
		out_vertex = out_vertex_q;
		normal_x   = out_nx_q;
		normal_y   = out_ny_q;
		normal_z   = out_nz_q;
		degenerate = out_deg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_CLEAR;
			clr_q      <= '0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_full_q <= 1'b1;
			end else if (pop) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				op_q  <= op_head;
				cnt_q <= '0;
			end
			B_TRI_RD: begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q != 2'd0) begin
					p_q[cnt_q - 2'd1] <= pos_rdata;
				end
			end
			B_EDGE: begin
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= pcomp(p_q[1], i) - pcomp(p_q[0], i);
					e2_q[i] <= pcomp(p_q[2], i) - pcomp(p_q[0], i);
				end
			end
			B_MUL: begin
				prod_q[0] <= e1_q[1] * e2_q[2];
				prod_q[1] <= e1_q[2] * e2_q[1];
				prod_q[2] <= e1_q[2] * e2_q[0];
				prod_q[3] <= e1_q[0] * e2_q[2];
				prod_q[4] <= e1_q[0] * e2_q[1];
				prod_q[5] <= e1_q[1] * e2_q[0];
			end
			B_CROSS: begin
				vec_q[0] <= VEC_W'(prod_q[0]) - VEC_W'(prod_q[1]);
				vec_q[1] <= VEC_W'(prod_q[2]) - VEC_W'(prod_q[3]);
				vec_q[2] <= VEC_W'(prod_q[4]) - VEC_W'(prod_q[5]);
			end
			B_WAIT: begin
				cnt_q <= '0;
			end
			B_ACC_WR: begin
				cnt_q <= cnt_q + 1'b1;
			end
			B_RD_DATA: begin
				vec_q[0] <= VEC_W'($signed(acc_rdata[ACW-1 -: AB]));
				vec_q[1] <= VEC_W'($signed(acc_rdata[2*AB-1 -: AB]));
				vec_q[2] <= VEC_W'($signed(acc_rdata[AB-1:0]));
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_vertex_q <= op_q.idx;
			if (op_q.kind == OP_READ_BAD) begin
				out_nx_q  <= '0;
				out_ny_q  <= '0;
				out_nz_q  <= '0;
				out_deg_q <= 1'b1;
			end else begin
				out_nx_q  <= unit_res.nx;
				out_ny_q  <= unit_res.ny;
				out_nz_q  <= unit_res.nz;
				out_deg_q <= !unit_res.ok;
			end
		end
	end

endmodule

/* rtl/core/vertex_normal_accumulator_core.sv */
// Vertex normal accumulator: smooth per-vertex normals of an indexed mesh.
// Top level; depends on vna_pkg, vna_front and vna_back.
//
// Items enter through a queue-style port: push with full; an item is taken
// at a clock edge with push high and full low. Load items store a position
// and clear that vertex's sum, triangle items add the unit face normal to
// all three corners, read items return one result on the output queue port.
// The result waits on the ports while empty is low and leaves on pop.
// A four-entry operation queue sits between the front and the sequencer, so
// items keep arriving while earlier ones are carried out, and a single
// output register holds a result while the receiver stalls; the sequencer
// waits for that register before finishing the next read.
// The normalizer runs a 32-step square root and three 15-step divisions.
// A load writes the position and clears the sum; a read fetches the sum and
// normalizes it, with no divisions for a zero sum; a triangle does three
// position reads, cross product, normalize and three accumulator
// read-modify-writes, or stops after normalize for a zero face normal. Rejected items cost nothing past entry.
// After reset a clearing pass over all MAX_VERTICES entries zeroes the accumulator
// RAM; full stays high until it ends.
module vertex_normal_accumulator_core import vna_pkg::*; #(
	parameter int MAX_VERTICES = 1024,
	parameter int ACCUM_BITS   = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [1:0]              cmd,
	input  logic [IDX_W-1:0]        vertex_index,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [IDX_W-1:0]        corner_a,
	input  logic [IDX_W-1:0]        corner_b,
	input  logic [IDX_W-1:0]        corner_c,
	output logic                    empty,
	input  logic                    pop,
	output logic [IDX_W-1:0]        out_vertex,
	output logic signed [NRM_W-1:0] normal_x,
	output logic signed [NRM_W-1:0] normal_y,
	output logic signed [NRM_W-1:0] normal_z,
	output logic                    degenerate
);

	logic accept;
	logic q_full;
	logic clearing;
	logic op_valid;
	logic op_take;
	op_t  op_head;

	assign full   = q_full || clearing;
	assign accept = push && !full;

	vna_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.vertex_index (vertex_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.op_take      (op_take),
		.op_valid     (op_valid),
		.op_head      (op_head),
		.q_full       (q_full)
	);

	vna_back #(.MAX_VERTICES(MAX_VERTICES), .ACCUM_BITS(ACCUM_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (op_valid),
		.op_head    (op_head),
		.op_take    (op_take),
		.clearing   (clearing),
		.empty      (empty),
		.pop        (pop),
		.out_vertex (out_vertex),
		.normal_x   (normal_x),
		.normal_y   (normal_y),
		.normal_z   (normal_z),
		.degenerate (degenerate)
	);

`ifndef SYNTHESIS
	// The sequencer never takes from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) op_take |-> op_valid)
		else $error("operation taken from empty queue");

	// Nothing can be queued while the accumulator RAM is being cleared.
	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> !op_valid)
		else $error("operation queued during clearing pass");

	// A degenerate result carries a zero normal.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && degenerate) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0))
		else $error("degenerate result with nonzero normal");

	// The x and y normal components stay within unit range.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (normal_x <= 16384 && normal_x >= -16384 &&
			normal_y <= 16384 && normal_y >= -16384))
		else $error("normal component out of unit range");
`endif

endmodule

/* tb/tb_vertex_normal_accumulator_core.sv */
// Self-checking testbench of vertex_normal_accumulator_core.
// Predicts every read result in SystemVerilog; depends on vna_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_vertex_normal_accumulator_core;
	import vna_pkg::*;

	localparam int NVERT = 1024;
	localparam int ABITS = 24;
	localparam longint ACC_HI = (64'sd1 <<< (ABITS - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [IDX_W-1:0] vtx;
		logic [NRM_W-1:0] nx;
		logic [NRM_W-1:0] ny;
		logic [NRM_W-1:0] nz;
		logic             deg;
	} normal_rec_t;

	typedef struct {
		longint x;
		longint y;
		longint z;
		bit     ok;
	} unit_vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [1:0] cmd = CMD_NONE;
	logic [IDX_W-1:0] vertex_index = '0;
	logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [IDX_W-1:0] corner_a = '0, corner_b = '0, corner_c = '0;
	logic full, empty, degenerate;
	logic [IDX_W-1:0] out_vertex;
	logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;

	vertex_normal_accumulator_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.vertex_index(vertex_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.empty(empty), .pop(pop), .out_vertex(out_vertex), .normal_x(normal_x),
		.normal_y(normal_y), .normal_z(normal_z), .degenerate(degenerate)
	);

	always #5 clk = ~clk;

	// Predictor state.
	logic signed [POS_W-1:0] vert_pos [NVERT][3];
	longint vert_sum [NVERT][3];
	int loaded_pool [$];
	bit is_loaded [NVERT];
	normal_rec_t pending_normals [$];
	int errors = 0;
	int idle_cycles = 0;
	int pop_stall = 0;

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 150);
		return $urandom_range(0, 3);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= root + bitv) begin
				s = s - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic unit_vec_t to_unit(input longint vx, input longint vy, input longint vz);
		unit_vec_t r;
		longint unsigned m [3];
		bit neg [3];
		longint v [3];
		longint unsigned mx, s, len, q;
		v[0] = vx; v[1] = vy; v[2] = vz;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = v[i] < 0;
			m[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
			if (m[i] > mx)
				mx = m[i];
		end
		// Scale down together until the largest magnitude is below 2^30.
		while (mx >= (64'd1 << 30)) begin
			mx = mx >> 1;
			for (int i = 0; i < 3; i++)
				m[i] = m[i] >> 1;
		end
		s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = int_sqrt(s);
		r.ok = len != 0;
		for (int i = 0; i < 3; i++) begin
			q = r.ok ? (m[i] * 16384 + len / 2) / len : 0;
			v[i] = neg[i] ? -longint'(q) : longint'(q);
		end
		r.x = v[0]; r.y = v[1]; r.z = v[2];
		return r;
	endfunction

	function automatic longint sat_sum(input longint a, input longint b);
		longint r;
		r = a + b;
		if (r > ACC_HI) r = ACC_HI;
		if (r < ACC_LO) r = ACC_LO;
		return r;
	endfunction

	task automatic predict_item(input logic [1:0] c, input int vi,
			input logic signed [POS_W-1:0] px, py, pz, input int ia, ib, ic);
		longint e1 [3], e2 [3];
		int crn [3];
		unit_vec_t u;
		normal_rec_t rec;
		if (c == CMD_LOAD) begin
			vert_pos[vi][0] = px; vert_pos[vi][1] = py; vert_pos[vi][2] = pz;
			for (int k = 0; k < 3; k++)
				vert_sum[vi][k] = 0;
			if (!is_loaded[vi]) begin
				is_loaded[vi] = 1;
				loaded_pool.push_back(vi);
			end
		end else if (c == CMD_TRI) begin
			for (int k = 0; k < 3; k++) begin
				e1[k] = longint'(vert_pos[ib][k]) - longint'(vert_pos[ia][k]);
				e2[k] = longint'(vert_pos[ic][k]) - longint'(vert_pos[ia][k]);
			end
			u = to_unit(e1[1] * e2[2] - e1[2] * e2[1], e1[2] * e2[0] - e1[0] * e2[2],
				e1[0] * e2[1] - e1[1] * e2[0]);
			if (u.ok) begin
				crn[0] = ia; crn[1] = ib; crn[2] = ic;
				for (int k = 0; k < 3; k++) begin
					vert_sum[crn[k]][0] = sat_sum(vert_sum[crn[k]][0], u.x);
					vert_sum[crn[k]][1] = sat_sum(vert_sum[crn[k]][1], u.y);
					vert_sum[crn[k]][2] = sat_sum(vert_sum[crn[k]][2], u.z);
				end
			end
		end else if (c == CMD_READ) begin
			u = to_unit(vert_sum[vi][0], vert_sum[vi][1], vert_sum[vi][2]);
			rec.vtx = IDX_W'(vi);
			rec.nx = u.x[NRM_W-1:0];
			rec.ny = u.y[NRM_W-1:0];
			rec.nz = u.z[NRM_W-1:0];
			rec.deg = !u.ok;
			pending_normals.push_back(rec);
		end
	endtask

	// Drives one item, waits for it to be taken, then idles a random gap.
	task automatic send_item(input logic [1:0] c, input int vi,
			input logic signed [POS_W-1:0] px, py, pz, input int ia, ib, ic);
		int gap;
		push <= 1'b1;
		cmd <= c;
		vertex_index <= IDX_W'(vi);
		pos_x <= px; pos_y <= py; pos_z <= pz;
		corner_a <= IDX_W'(ia); corner_b <= IDX_W'(ib); corner_c <= IDX_W'(ic);
		do @(posedge clk); while (full);
		predict_item(c, vi, px, py, pz, ia, ib, ic);
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_vertex(input int vi, input int px, py, pz);
		send_item(CMD_LOAD, vi, POS_W'(px), POS_W'(py), POS_W'(pz),
			$urandom, $urandom, $urandom);
	endtask

	task automatic add_triangle(input int ia, ib, ic);
		send_item(CMD_TRI, $urandom, POS_W'($urandom), POS_W'($urandom),
			POS_W'($urandom), ia, ib, ic);
	endtask

	task automatic read_normal(input int vi);
		send_item(CMD_READ, vi, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
			$urandom, $urandom, $urandom);
	endtask

	task automatic test_basic_triangle();
		load_vertex(0, 0, 0, 0);
		load_vertex(1, 256, 0, 0);
		load_vertex(2, 0, 256, 0);
		read_normal(0);
		add_triangle(0, 1, 2);
		read_normal(0);
		read_normal(1);
		read_normal(2);
		// Unused command gives no result.
		send_item(CMD_NONE, 5, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
			0, 1, 2);
	endtask

	task automatic test_degenerate_cases();
		add_triangle(1, 1, 2);
		add_triangle(0, 0, 0);
		load_vertex(3, 512, 512, 0);
		add_triangle(0, 3, 3);
		read_normal(3);
		// Reloading clears the sum.
		load_vertex(1, 256, 0, 0);
		read_normal(1);
		read_normal(1023);
	endtask

	task automatic test_extreme_positions();
		load_vertex(1023, 16'sh8000, 16'sh8000, 16'sh8000);
		load_vertex(1022, 16'sh7fff, 16'sh8000, 16'sh7fff);
		load_vertex(1021, 16'sh8000, 16'sh7fff, 16'sh7fff);
		load_vertex(512, 16'sh7fff, 16'sh7fff, 16'sh8000);
		add_triangle(1023, 1022, 1021);
		add_triangle(512, 1022, 1021);
		read_normal(1023);
		read_normal(1021);
		read_normal(512);
	endtask

	task automatic test_accum_saturation();
		load_vertex(10, 0, 0, 0);
		load_vertex(11, 256, 0, 0);
		load_vertex(12, 0, 256, 0);
		repeat (520) add_triangle(10, 11, 12);
		read_normal(10);
		repeat (1040) add_triangle(10, 12, 11);
		read_normal(10);
		read_normal(11);
	endtask

	task automatic test_random_mesh();
		int sel, vi;
		logic signed [POS_W-1:0] px, py, pz;
		for (int n = 0; n < 450; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 12) begin
				vi = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 1023);
				px = POS_W'($urandom); py = POS_W'($urandom); pz = POS_W'($urandom);
				if ($urandom_range(0, 2) == 0) begin
					px = px >>> 8; py = py >>> 8; pz = pz >>> 8;
				end
				load_vertex(vi, px, py, pz);
			end else if (sel < 70) begin
				add_triangle(loaded_pool[$urandom_range(0, loaded_pool.size() - 1)],
					loaded_pool[$urandom_range(0, loaded_pool.size() - 1)],
					loaded_pool[$urandom_range(0, loaded_pool.size() - 1)]);
			end else if (sel < 95) begin
				if ($urandom_range(0, 4) == 0)
					read_normal($urandom_range(0, 1023));
				else
					read_normal(loaded_pool[$urandom_range(0, loaded_pool.size() - 1)]);
			end else begin
				send_item(CMD_NONE, $urandom, POS_W'($urandom), POS_W'($urandom),
					POS_W'($urandom), $urandom, $urandom, $urandom);
			end
		end
	endtask

	// Result side: idle count for the watchdog, random pop stalls and comparison against the oldest prediction.
	always @(posedge clk) begin
		normal_rec_t want;
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (pop && !empty) begin
				if (pending_normals.size() == 0) begin
					$display("%0t: unexpected result vertex %0d", $time, out_vertex);
					errors++;
				end else begin
					want = pending_normals.pop_front();
					if (out_vertex !== want.vtx || normal_x !== want.nx ||
							normal_y !== want.ny || normal_z !== want.nz ||
							degenerate !== want.deg) begin
						$display("%0t: expected v%0d (%0d %0d %0d) deg %0b, got v%0d (%0d %0d %0d) deg %0b",
							$time, want.vtx, $signed(want.nx), $signed(want.ny),
							$signed(want.nz), want.deg, out_vertex, normal_x, normal_y,
							normal_z, degenerate);
						errors++;
					end
				end
			end
			if (pop_stall > 0) begin
				pop_stall <= pop_stall - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					pop_stall <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NVERT; i++) begin
			is_loaded[i] = 0;
			for (int k = 0; k < 3; k++) begin
				vert_pos[i][k] = 0;
				vert_sum[i][k] = 0;
			end
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_triangle();
		test_degenerate_cases();
		test_extreme_positions();
		test_accum_saturation();
		test_random_mesh();
		push <= 1'b0;
		while (pending_normals.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending_normals.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
